>>> rtl/rpab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpab_pkg
// Shared types, register indexes and helpers for the RGBA pixel blender.
// ----------------------------------------------------------------------------
package rpab_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_SRC_ORDER = 2'd0;
	localparam logic [1:0] REG_DST_ORDER = 2'd1;
	localparam logic [1:0] REG_BLEND_EN  = 2'd2;

	localparam logic [7:0] ORDER_RESET  = 8'hE4;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam int unsigned NUM_COLORS  = 3;
	localparam int unsigned CH_ALPHA    = 3;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] sum_t;

	// Operands after byte extraction.
	typedef struct packed {
		logic                       blend;
		byte_t                      alpha;
		logic [NUM_COLORS-1:0][7:0] src_c;
		logic [NUM_COLORS-1:0][7:0] dst_c;
		logic [7:0]                 dst_order;
		logic [31:0]                src;
		logic [31:0]                dst;
	} unpack_t;

	// Weighted sums ahead of the divide by 255.
	typedef struct packed {
		logic                        blend;
		logic [NUM_COLORS-1:0][15:0] sum;
		logic [7:0]                  dst_order;
		logic [31:0]                 src;
		logic [31:0]                 dst;
	} mac_t;

	function automatic logic [1:0] chan_pos(input logic [7:0] order, input int unsigned chan);
		logic [1:0] pos;
		pos = order[2*chan +: 2];
		return pos;
	endfunction

	function automatic byte_t byte_at(input logic [31:0] word, input logic [1:0] pos);
		byte_t b;
		b = word[{pos, 3'b000} +: 8];
		return b;
	endfunction

endpackage

>>> rtl/rpab_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpab_unpack
// First stage: picks the color bytes out of both pixel words and alpha out of src.
// ----------------------------------------------------------------------------
module rpab_unpack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [31:0]       src_pixel,
	input  logic [31:0]       dst_pixel,
	input  logic [7:0]        src_order,
	input  logic [7:0]        dst_order,
	input  logic              blend,
	output logic              valid_s1,
	output rpab_pkg::unpack_t data_s1
);

	rpab_pkg::unpack_t data_d;

	always_comb begin
		data_d.blend     = blend;
		data_d.alpha     = rpab_pkg::byte_at(src_pixel,
			rpab_pkg::chan_pos(src_order, rpab_pkg::CH_ALPHA));
		for (int unsigned c = 0; c < rpab_pkg::NUM_COLORS; c++) begin
			data_d.src_c[c] = rpab_pkg::byte_at(src_pixel, rpab_pkg::chan_pos(src_order, c));
			data_d.dst_c[c] = rpab_pkg::byte_at(dst_pixel, rpab_pkg::chan_pos(dst_order, c));
		end
		data_d.dst_order = dst_order;
		data_d.src       = src_pixel;
		data_d.dst       = dst_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= data_d;
		end
	end

endmodule

>>> rtl/rpab_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpab_mac
// Second stage: forms src*a + (255-a)*dst for each color channel.
// ----------------------------------------------------------------------------
module rpab_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  rpab_pkg::unpack_t data_s1,
	output logic              valid_s2,
	output rpab_pkg::mac_t    data_s2
);

	rpab_pkg::mac_t data_d;
	rpab_pkg::byte_t inv_alpha;

	always_comb begin
		inv_alpha     = rpab_pkg::ALPHA_OPAQUE - data_s1.alpha;
		data_d.blend  = data_s1.blend;
		for (int unsigned c = 0; c < rpab_pkg::NUM_COLORS; c++) begin
			// Both products stay below 2^16 and so does their sum (at most 255*255).
			data_d.sum[c] = 16'(data_s1.src_c[c]) * 16'(data_s1.alpha)
				+ 16'(data_s1.dst_c[c]) * 16'(inv_alpha);
		end
		data_d.dst_order = data_s1.dst_order;
		data_d.src       = data_s1.src;
		data_d.dst       = data_s1.dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= data_d;
		end
	end

endmodule

>>> rtl/rpab_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpab_pack
// Third stage: divides by 255 and writes into the dst word, or copies src.
// ----------------------------------------------------------------------------
module rpab_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  rpab_pkg::mac_t data_s2,
	output logic           out_valid,
	output logic [31:0]    out_pixel
);

	logic [rpab_pkg::NUM_COLORS-1:0][7:0] quot;
	logic [31:0] res;
	rpab_pkg::sum_t t;

	always_comb begin
		t = '0;
		for (int unsigned c = 0; c < rpab_pkg::NUM_COLORS; c++) begin
			// Exact floor(x/255) for x up to 255*255: (x + (x >> 8) + 1) >> 8.
			t = data_s2.sum[c] + {8'h00, data_s2.sum[c][15:8]} + 16'd1;
			quot[c] = t[15:8];
		end
	end

	always_comb begin
		if (data_s2.blend) begin
			// Writes go red, green, blue, then alpha, so a later channel wins a shared byte.
			res = data_s2.dst;
			for (int unsigned c = 0; c < rpab_pkg::NUM_COLORS; c++) begin
				res[{rpab_pkg::chan_pos(data_s2.dst_order, c), 3'b000} +: 8] = quot[c];
			end
			res[{rpab_pkg::chan_pos(data_s2.dst_order, rpab_pkg::CH_ALPHA), 3'b000} +: 8] =
				rpab_pkg::ALPHA_OPAQUE;
		end else begin
			res = data_s2.src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			out_pixel <= res;
		end
	end

endmodule

>>> rtl/rgba_pixel_alpha_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_alpha_blend
// Source-over compositor for 32-bit RGBA pixels with configurable byte order.
// Each beat taken passes the three pipeline registers (unpack, mac, pack)
// before it shows on out_pixel with out_valid.
// Throughput: one pixel pair per clock; busy is never raised.
// Reset clears the stage valid bits and sets both channel orders to 0xE4
// and blending off. The receiver cannot stall the pipeline.
// ----------------------------------------------------------------------------
module rgba_pixel_alpha_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	output logic        out_valid,
	output logic [31:0] out_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] src_order_q;
	logic [7:0] dst_order_q;
	logic       blend_q;
	logic       in_valid;

	logic              valid_s1;
	rpab_pkg::unpack_t data_s1;
	logic              valid_s2;
	rpab_pkg::mac_t    data_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_valid  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_order_q <= rpab_pkg::ORDER_RESET;
			dst_order_q <= rpab_pkg::ORDER_RESET;
			blend_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpab_pkg::REG_SRC_ORDER: src_order_q <= cfg_data;
				rpab_pkg::REG_DST_ORDER: dst_order_q <= cfg_data;
				rpab_pkg::REG_BLEND_EN:  blend_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rpab_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.src_pixel (src_pixel),
		.dst_pixel (dst_pixel),
		.src_order (src_order_q),
		.dst_order (dst_order_q),
		.blend     (blend_q),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1)
	);

	rpab_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	rpab_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.data_s2   (data_s2),
		.out_valid (out_valid),
		.out_pixel (out_pixel)
	);

`ifndef ASSERT_OFF
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline never stalls");

	a_out_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(valid_s1, 2))
		else $error("result beat without a matching first-stage beat");

	a_copy_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !data_s2.blend) |=> (out_pixel == $past(data_s2.src)))
		else $error("copy mode changed the source word");

	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && data_s2.blend) |=>
		(rpab_pkg::byte_at(out_pixel, $past(data_s2.dst_order[7:6]))
			== rpab_pkg::ALPHA_OPAQUE))
		else $error("blended beat lacks an opaque alpha byte");
`endif

endmodule
